### hw/rtl/rre_pkg.sv
// Shared types and codes for the run-length row expander.
// Used by rre_ctrl, rre_datapath, rle_row_expander and rre_checker.
package rre_pkg;

    localparam int CFG_DATA_W = 16;
    localparam int SAMPLE_W   = 16;
    localparam int COUNT_W    = 7;

    // register indexes on the configuration port
    localparam logic CFG_SAMPLE_BYTES = 1'b0;
    localparam logic CFG_ROW_WIDTH    = 1'b1;

    localparam logic [1:0] SAMPLE_BYTES_WIDE = 2'd2;
    localparam logic [1:0] LANES_NONE        = 2'd0;
    localparam logic [1:0] LANES_TWO         = 2'd2;

    typedef enum logic [1:0] {
        MODE_DATA  = 2'd0,
        MODE_START = 2'd1,
        MODE_END   = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        OUT_PROGRESS = 2'd0,
        OUT_COMPLETE = 2'd1,
        OUT_ERROR    = 2'd2
    } outcome_t;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_LITERAL = 2'd1,
        PH_RUN     = 2'd2,
        PH_DONE    = 2'd3
    } phase_t;

    typedef enum logic {
        CS_IDLE = 1'b0,
        CS_EMIT = 1'b1
    } ctrl_state_t;

    typedef struct packed {
        mode_t      mode;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_first;
        logic [SAMPLE_W-1:0] sample_second;
        logic [1:0]          lane_count;
        outcome_t            status;
        logic                last;
    } out_item_t;

    typedef struct packed {
        logic accept;   // take the input item, update row state
        logic load;     // load next result into the output register
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;   // output register can take a result this cycle
        logic emit_last;  // next result is the final one of the item
    } dp_status_t;

endpackage

### hw/rtl/rle_row_expander.sv
// Channel   Handshake                  Payload
// item      item_valid / item_ready    in_item_t  {mode, data_byte}
// result    result_valid / result_ready out_item_t {samples, lanes, status, last}
// cfg       cfg_we                     cfg_index, cfg_data
//
// An item is accepted, then its n samples leave up to two per result through
// the single output register; an item gives max(1, ceil(n/2)) results and a
// run holds up to 127 samples. item_ready drops from acceptance until the
// item's last result is loaded; result_ready low holds the emit sequence.
// Reset sets sample_bytes to 1, row_width to 1 and the row to awaiting header.
// Top level: depends on rre_pkg, rre_ctrl and rre_datapath.
module rle_row_expander (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic                            cfg_index,
    input  logic [rre_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            item_valid,
    output logic                            item_ready,
    input  rre_pkg::in_item_t               item,
    output logic                            result_valid,
    input  logic                            result_ready,
    output rre_pkg::out_item_t              result
);
    import rre_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    rre_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .status     (status),
        .cmd        (cmd)
    );

    rre_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item         (item),
        .result_ready (result_ready),
        .cmd          (cmd),
        .status       (status),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

### hw/rtl/rre_ctrl.sv
// Controller for the run-length row expander: accept / emit sequencing.
// Depends on rre_pkg; drives rre_datapath through dp_cmd_t.
module rre_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  rre_pkg::dp_status_t status,
    output rre_pkg::dp_cmd_t    cmd
);
    import rre_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        item_ready = 1'b0;
        cmd.accept = 1'b0;
        cmd.load   = 1'b0;
        case (state_reg)
            CS_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = CS_EMIT;
                end
            end
            CS_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.load = 1'b1;
                    if (status.emit_last)
                    begin
                        state_next = CS_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end

endmodule

### hw/rtl/rre_datapath.sv
// Datapath for the run-length row expander: config registers, row state,
// sample/emit counter and the output register. Depends on rre_pkg.
module rre_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic                            cfg_index,
    input  logic [rre_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  rre_pkg::in_item_t               item,
    input  logic                            result_ready,
    input  rre_pkg::dp_cmd_t                cmd,
    output rre_pkg::dp_status_t             status,
    output logic                            result_valid,
    output rre_pkg::out_item_t              result
);
    import rre_pkg::*;

    logic [1:0]          sample_bytes_reg;
    logic [15:0]         row_width_reg;

    phase_t              phase_reg,   phase_next;
    logic [COUNT_W-1:0]  rem_reg,     rem_next;
    logic [15:0]         sw_reg,      sw_next;
    logic [7:0]          held_reg,    held_next;
    logic                parity_reg,  parity_next;
    outcome_t            outcome_reg, outcome_next;
    logic [SAMPLE_W-1:0] sample_reg,  sample_next;
    logic [COUNT_W-1:0]  emit_reg,    emit_next;
    logic                res_valid_reg;
    out_item_t           res_reg;

    logic                wide;
    logic                sw_full;
    logic [COUNT_W-1:0]  payload_n;
    logic [COUNT_W-1:0]  rem_dec;
    logic [15:0]         sw_after;
    logic                after_full;
    logic [16:0]         hdr_sum;
    logic                hdr_over;
    logic [COUNT_W-1:0]  hdr_cnt;
    logic                emit_last;

    assign wide       = (sample_bytes_reg == SAMPLE_BYTES_WIDE);
    assign sw_full    = (sw_reg >= row_width_reg);
    assign hdr_cnt    = item.data_byte[COUNT_W-1:0];
    assign hdr_sum    = {1'b0, sw_reg} + {10'b0, hdr_cnt};
    assign hdr_over   = (hdr_sum > {1'b0, row_width_reg});
    assign payload_n  = (phase_reg == PH_LITERAL && item.mode == MODE_DATA) ?
                        7'd1 : rem_reg;
    assign rem_dec    = rem_reg - 7'd1;
    assign sw_after   = sw_reg + {9'b0, payload_n};
    assign after_full = (sw_after >= row_width_reg);

    // row state update for one accepted item
    always_comb
    begin
        phase_next   = phase_reg;
        rem_next     = rem_reg;
        sw_next      = sw_reg;
        held_next    = held_reg;
        parity_next  = parity_reg;
        outcome_next = outcome_reg;
        sample_next  = '0;
        emit_next    = '0;
        case (item.mode)
            MODE_DATA:
            begin
                case (phase_reg)
                    PH_HEADER:
                    begin
                        if (sw_full)
                        begin
                            outcome_next = OUT_COMPLETE;
                            phase_next   = PH_DONE;
                            rem_next     = '0;
                            parity_next  = 1'b0;
                        end
                        else if (wide && !parity_reg)
                        begin
                            parity_next = 1'b1;
                            held_next   = item.data_byte;
                        end
                        else if (hdr_cnt == '0 || hdr_over)
                        begin
                            // zero count before row is full, or count too large
                            outcome_next = OUT_ERROR;
                            phase_next   = PH_DONE;
                            rem_next     = '0;
                            parity_next  = 1'b0;
                        end
                        else
                        begin
                            parity_next = 1'b0;
                            rem_next    = hdr_cnt;
                            phase_next  = item.data_byte[7] ? PH_LITERAL : PH_RUN;
                        end
                    end
                    PH_LITERAL, PH_RUN:
                    begin
                        if (wide && !parity_reg)
                        begin
                            parity_next = 1'b1;
                            held_next   = item.data_byte;
                        end
                        else
                        begin
                            sample_next = wide ? {held_reg, item.data_byte} :
                                                 {8'b0, item.data_byte};
                            emit_next   = payload_n;
                            sw_next     = sw_after;
                            parity_next = 1'b0;
                            if (phase_reg == PH_LITERAL && rem_dec != '0)
                            begin
                                rem_next = rem_dec;
                            end
                            else
                            begin
                                rem_next = '0;
                                if (after_full)
                                begin
                                    outcome_next = OUT_COMPLETE;
                                    phase_next   = PH_DONE;
                                end
                                else
                                begin
                                    phase_next = PH_HEADER;
                                end
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            MODE_START:
            begin
                phase_next   = PH_HEADER;
                rem_next     = '0;
                sw_next      = '0;
                held_next    = '0;
                parity_next  = 1'b0;
                outcome_next = OUT_PROGRESS;
            end
            MODE_END:
            begin
                if (phase_reg != PH_DONE)
                begin
                    phase_next  = PH_DONE;
                    rem_next    = '0;
                    parity_next = 1'b0;
                    if (phase_reg == PH_HEADER)
                    begin
                        outcome_next = sw_full ? OUT_COMPLETE : OUT_ERROR;
                    end
                    else
                    begin
                        // zero-fill the rest of the payload
                        emit_next    = rem_reg;
                        sw_next      = sw_after;
                        outcome_next = after_full ? OUT_COMPLETE : OUT_ERROR;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_bytes_reg <= 2'd1;
            row_width_reg    <= 16'd1;
            phase_reg        <= PH_HEADER;
            rem_reg          <= '0;
            sw_reg           <= '0;
            held_reg         <= '0;
            parity_reg       <= 1'b0;
            outcome_reg      <= OUT_PROGRESS;
            sample_reg       <= '0;
            emit_reg         <= '0;
            res_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == CFG_SAMPLE_BYTES)
            begin
                sample_bytes_reg <= cfg_data[1:0];
            end
            if (cfg_we && cfg_index == CFG_ROW_WIDTH)
            begin
                row_width_reg <= cfg_data[15:0];
            end
            if (cmd.accept)
            begin
                phase_reg   <= phase_next;
                rem_reg     <= rem_next;
                sw_reg      <= sw_next;
                held_reg    <= held_next;
                parity_reg  <= parity_next;
                outcome_reg <= outcome_next;
                sample_reg  <= sample_next;
                emit_reg    <= emit_next;
            end
            else if (cmd.load)
            begin
                emit_reg <= emit_last ? '0 : emit_reg - 7'd2;
            end
            if (cmd.load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // every sample of one item carries the same value; up to two per transfer
    assign emit_last = (emit_reg <= 7'd2);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            res_reg.sample_first  <= (emit_reg != '0) ? sample_reg : '0;
            res_reg.sample_second <= (emit_reg >= 7'd2) ? sample_reg : '0;
            res_reg.lane_count    <= (emit_reg >= 7'd2) ? LANES_TWO : emit_reg[1:0];
            res_reg.status        <= emit_last ? outcome_reg : OUT_PROGRESS;
            res_reg.last          <= emit_last;
        end
    end

    assign status.out_free  = !res_valid_reg || result_ready;
    assign status.emit_last = emit_last;
    assign result_valid     = res_valid_reg;
    assign result           = res_reg;

endmodule

### hw/rtl/rre_checker.sv
// Port-level checks for rle_row_expander, attached by bind.
// Depends on rre_pkg.
module rre_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                item_valid,
    input logic                item_ready,
    input logic                result_valid,
    input logic                result_ready,
    input rre_pkg::out_item_t  result
);
    import rre_pkg::*;

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("item accepted while previous one in flight");

    a_status_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last |-> result.status == OUT_PROGRESS)
        else $error("row outcome reported before last transfer");

    a_full_before_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last |-> result.lane_count == LANES_TWO)
        else $error("partial transfer before last");

    a_empty_lanes_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.lane_count == LANES_NONE |->
            result.sample_first == '0 && result.sample_second == '0)
        else $error("empty transfer carries sample data");

endmodule

bind rle_row_expander rre_checker u_rre_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);
